// ===== src/l1dt_pkg.sv =====
`default_nettype none

package l1dt_pkg;

	localparam int TILE_ROWS = 8;
	localparam int TILE_COLS = 4;
	localparam int TILE_SIZE = TILE_ROWS * TILE_COLS;
	localparam int COORD_W = 32;
	localparam int MAG_W = 32;
	localparam int SUM_W = 48;
	localparam int ROW_W = 3;
	localparam int COL_W = 2;
	localparam int SEL_W = ROW_W + COL_W;
	localparam int DEPTH_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W = (TILE_ROWS + TILE_COLS) * COORD_W;
	localparam int OUT_FIELD_W = SUM_W + ROW_W + COL_W;
	localparam int OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELD_W;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(TILE_SIZE - 1);

	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCUM_PRIOR = 1'd1;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic emit;
		logic [SEL_W-1:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== src/l1dt_datapath.sv =====
`default_nettype none

module l1dt_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [l1dt_pkg::IN_DATA_W-1:0] in_data,
	input  wire l1dt_pkg::dp_cmd_t              cmd,
	output l1dt_pkg::dp_status_t                status,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [l1dt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast
);
	import l1dt_pkg::*;

	logic [MAG_W-1:0] mag_c [TILE_SIZE];
	logic [MAG_W-1:0] mag_s1 [TILE_SIZE];
	logic valid_s1;
	logic clear_s1;
	logic [SUM_W-1:0] sums_q [TILE_SIZE];
	logic [SUM_W-1:0] sum_next [TILE_SIZE];
	logic out_valid_q;
	logic [SUM_W-1:0] dist_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic last_q;

	always_comb begin
		logic signed [COORD_W:0] a_ext;
		logic signed [COORD_W:0] b_ext;
		logic signed [COORD_W:0] diff;
		logic [COORD_W:0] magn;
		for (int j = 0; j < TILE_COLS; j++) begin
			for (int i = 0; i < TILE_ROWS; i++) begin
				a_ext = {in_data[i*COORD_W + COORD_W - 1], in_data[i*COORD_W +: COORD_W]};
				b_ext = {in_data[(TILE_ROWS + j)*COORD_W + COORD_W - 1],
					in_data[(TILE_ROWS + j)*COORD_W +: COORD_W]};
				diff = a_ext - b_ext;
				magn = diff[COORD_W] ? (~diff + 1'b1) : diff;
				mag_c[j*TILE_ROWS + i] = magn[MAG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			for (int k = 0; k < TILE_SIZE; k++) begin
				mag_s1[k] <= mag_c[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			clear_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			clear_s1 <= cmd.step & cmd.clear;
		end
	end

	always_comb begin
		logic [SUM_W-1:0] base;
		logic [SUM_W:0] total;
		for (int k = 0; k < TILE_SIZE; k++) begin
			base = clear_s1 ? '0 : sums_q[k];
			total = {1'b0, base} + (SUM_W+1)'(mag_s1[k]);
			sum_next[k] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TILE_SIZE; k++) begin
				sums_q[k] <= '0;
			end
		end else if (valid_s1) begin
			for (int k = 0; k < TILE_SIZE; k++) begin
				sums_q[k] <= sum_next[k];
			end
		end
	end

	assign status.out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dist_q <= sums_q[cmd.sel];
			row_q <= cmd.sel[ROW_W-1:0];
			col_q <= cmd.sel[SEL_W-1:ROW_W];
			last_q <= (cmd.sel == SEL_LAST);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, col_q, row_q, dist_q};
	assign m_axis_tlast = last_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("Result loaded while the output register is still occupied.");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (row_q == ROW_W'(TILE_ROWS - 1)
			&& col_q == COL_W'(TILE_COLS - 1)))
		else $error("Final tile entry carries the wrong position.");

	a_no_accum_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !valid_s1)
		else $error("Tile read while an accumulation is still in flight.");

endmodule

`default_nettype wire

// ===== src/l1dt_ctrl.sv =====
`default_nettype none

module l1dt_ctrl #(
	parameter int MAX_DEPTH = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [l1dt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [l1dt_pkg::DEPTH_W-1:0]   cfg_data,
	output l1dt_pkg::dp_cmd_t                   cmd,
	input  wire l1dt_pkg::dp_status_t           status
);
	import l1dt_pkg::*;

	localparam int CNT_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CMP_W = ((CNT_W > DEPTH_W) ? CNT_W : DEPTH_W) + 2;

	state_t state_q;
	state_t state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [SEL_W-1:0] idx_q;
	logic [DEPTH_W-1:0] depth_q;
	logic accum_prior_q;
	logic accept;
	logic tile_done;
	logic [CMP_W-1:0] eff_depth;
	logic [CMP_W-1:0] cnt_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_W'(1);
			accum_prior_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEPTH: depth_q <= cfg_data;
				REG_ACCUM_PRIOR: accum_prior_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (depth_q == '0) begin
			eff_depth = CMP_W'(1);
		end else if (CMP_W'(depth_q) > CMP_W'(MAX_DEPTH)) begin
			eff_depth = CMP_W'(MAX_DEPTH);
		end else begin
			eff_depth = CMP_W'(depth_q);
		end
		cnt_next = CMP_W'(cnt_q) + CMP_W'(1);
		tile_done = (cnt_next >= eff_depth);
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		cmd.step = 1'b0;
		cmd.clear = (cnt_q == '0) && !accum_prior_q;
		cmd.emit = 1'b0;
		cmd.sel = idx_q;
		case (state_q)
			ST_ACCUM: begin
				s_axis_tready = 1'b1;
				cmd.step = s_axis_tvalid;
				if (s_axis_tvalid && tile_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
				if (status.out_free && idx_q == SEL_LAST) begin
					state_d = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= tile_done ? '0 : cnt_next[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && cmd.emit))
		else $error("Input transfer accepted while the tile is being emitted.");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) < CMP_W'(MAX_DEPTH))
		else $error("Step counter exceeds the maximum depth.");

	a_flush_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (state_q == ST_EMIT && idx_q == '0))
		else $error("Emission did not start at the first tile entry.");

	a_done_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && tile_done) |=> (state_q == ST_FLUSH && cnt_q == '0))
		else $error("Completed tile did not start its flush.");

endmodule

`default_nettype wire

// ===== src/l1_distance_tile_8x4_top.sv =====
// L1 distance tile, 8 reference points by 4 query points.
// Each transfer on the s_axis channel is one dimension step: eight reference
// coordinates and four query coordinates, all signed Q16.16. The block adds
// the absolute difference of every pair into 32 saturating 48-bit sums.
// Steps that do not complete a tile are taken one per cycle.
// The step that completes a tile (after depth steps) moves the controller
// through the flush state into the emit state, where results are loaded.
// The 32 results then leave on m_axis one per cycle while the receiver is
// ready, column-major, with tlast on the final entry; s_axis is held off until
// the last result is loaded into the output register.
// When the receiver stalls, the output register holds its result and the
// emission pauses; the tile sums are unaffected.
// The cfg channel is always ready: index 0 writes depth, index 1 writes
// accumulate_prior. Write it only while the block is idle.
// Reset clears all sums and the step counter, sets depth to 1 and
// accumulate_prior to 0.
`default_nettype none

module l1_distance_tile_8x4_top #(
	parameter int MAX_DEPTH = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// a_row0..a_row7, then b_col0..b_col3, 32 bits each.
	input  wire logic [l1dt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// distance (48), row_index (3), col_index (2), zero padding (3).
	output logic [l1dt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                 m_axis_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [l1dt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [l1dt_pkg::DEPTH_W-1:0]    cfg_data
);
	import l1dt_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;

	l1dt_ctrl #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status)
	);

	l1dt_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(s_axis_tdata),
		.cmd(cmd),
		.status(status),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import l1dt_pkg::*;

	localparam int MAX_DEPTH = 1024;
	localparam int LIMIT = 1000000;
	localparam int SETTLE = 8;

	typedef struct packed {
		logic [SUM_W-1:0] distance;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic last;
	} tile_entry_t;

	typedef enum logic {
		ROW_CFG,
		ROW_STEP
	} plan_kind_t;

	typedef struct {
		plan_kind_t kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [DEPTH_W-1:0] reg_val;
		logic [COORD_W-1:0] a_val;
		logic [COORD_W-1:0] b_val;
		int reps;
		bit typed;
		logic [SUM_W-1:0] distance;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_axis_tready;
	logic m_axis_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DEPTH_W-1:0] cfg_data = '0;

	int src_idle = 11;
	int sink_idle = 82;
	int mismatches = 0;
	int unsigned cycles = 0;

	logic [SUM_W-1:0] pred_sums [TILE_SIZE];
	int unsigned pred_steps = 0;
	logic [DEPTH_W-1:0] pred_depth = DEPTH_W'(1);
	logic pred_accum = 1'b0;
	tile_entry_t pending_distances [$];
	tile_entry_t head;
	bit typed_on = 1'b0;
	logic [SUM_W-1:0] typed_distance = '0;

	// Every step of a row carries the same coordinate on all reference points and
	// another on all query points, so a typed distance is the same for the whole tile.
	plan_row_t plan [27] = '{
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b1, 48'h0000_FFFF_FFFF},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b1, 48'h0000_FFFF_FFFF},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'hFFFF_FFFF, 32'h0000_0001, 1, 1'b1, 48'h2},
		'{ROW_CFG, REG_DEPTH, 11'd0, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0000_0005, 32'h0000_0003, 1, 1'b1, 48'h2},
		'{ROW_CFG, REG_DEPTH, 11'd3, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0001_0000, 32'h0000_0000, 3, 1'b1, 48'h3_0000},
		'{ROW_CFG, REG_ACCUM_PRIOR, 11'd1, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0001_0000, 32'h0000_0000, 3, 1'b1, 48'h6_0000},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h1234_5678, 32'hFEDC_BA98, 2, 1'b0, 48'h0},
		'{ROW_CFG, REG_DEPTH, 11'd2, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h8000_0000, 32'h0000_0000, 1, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0000_0001, 32'h0000_0002, 1, 1'b0, 48'h0},
		'{ROW_CFG, REG_ACCUM_PRIOR, 11'd0, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0000_0003, 32'h0000_0004, 1, 1'b0, 48'h0},
		'{ROW_CFG, REG_DEPTH, 11'h7FF, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h7FFF_FFFF, 32'h8000_0000, 4, 1'b0, 48'h0},
		'{ROW_CFG, REG_DEPTH, 11'd1, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b1,
			48'h0004_FFFF_FFFB},
		'{ROW_CFG, REG_ACCUM_PRIOR, 11'd1, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0000_0000, 32'h0000_0000, 1, 1'b1,
			48'h0004_FFFF_FFFB},
		'{ROW_CFG, REG_ACCUM_PRIOR, 11'd0, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_CFG, REG_DEPTH, 11'd1024, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0000_0001, 32'h0000_0000, 3, 1'b0, 48'h0},
		'{ROW_CFG, REG_DEPTH, 11'd2, 32'h0, 32'h0, 0, 1'b0, 48'h0},
		'{ROW_STEP, REG_DEPTH, 11'd0, 32'h0000_0001, 32'h0000_0000, 1, 1'b1, 48'h4}
	};

	l1_distance_tile_8x4_top #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		foreach (pred_sums[k])
			pred_sums[k] = '0;
	end

	task automatic predict_step(input logic [IN_DATA_W-1:0] d);
		logic signed [COORD_W:0] a;
		logic signed [COORD_W:0] b;
		logic signed [COORD_W:0] diff;
		logic [SUM_W:0] total;
		int unsigned steps_per_tile;
		tile_entry_t e;
		if (pred_steps == 0 && !pred_accum) begin
			foreach (pred_sums[k])
				pred_sums[k] = '0;
		end
		for (int j = 0; j < TILE_COLS; j++) begin
			for (int i = 0; i < TILE_ROWS; i++) begin
				a = $signed(d[i*COORD_W +: COORD_W]);
				b = $signed(d[(TILE_ROWS+j)*COORD_W +: COORD_W]);
				diff = a - b;
				if (diff < 0)
					diff = -diff;
				total = {1'b0, pred_sums[j*TILE_ROWS+i]} + diff[COORD_W-1:0];
				pred_sums[j*TILE_ROWS+i] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
			end
		end
		pred_steps++;
		steps_per_tile = (pred_depth == 0) ? 1 : (pred_depth > MAX_DEPTH) ? MAX_DEPTH : pred_depth;
		if (pred_steps >= steps_per_tile) begin
			pred_steps = 0;
			for (int j = 0; j < TILE_COLS; j++) begin
				for (int i = 0; i < TILE_ROWS; i++) begin
					e.distance = typed_on ? typed_distance : pred_sums[j*TILE_ROWS+i];
					e.row = ROW_W'(i);
					e.col = COL_W'(j);
					e.last = (j == TILE_COLS - 1) && (i == TILE_ROWS - 1);
					pending_distances.push_back(e);
				end
			end
		end
	endtask

	task automatic push_step(input logic [IN_DATA_W-1:0] d);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_step(d);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DEPTH_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DEPTH)
			pred_depth = val;
		else
			pred_accum = val[0];
		@(posedge clk);
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return COORD_W'(int'($urandom_range(0, 512)) - 256);
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_tready) begin
			if (pending_distances.size() == 0) begin
				mismatches++;
				$display("%0t: result transfer with none expected, tdata %h tlast %b", $time,
					m_axis_tdata, m_axis_tlast);
			end else begin
				head = pending_distances.pop_front();
				if (m_axis_tdata[SUM_W-1:0] !== head.distance) begin
					mismatches++;
					$display("%0t: distance expected %h got %h", $time, head.distance,
						m_axis_tdata[SUM_W-1:0]);
				end
				if (m_axis_tdata[SUM_W +: ROW_W] !== head.row) begin
					mismatches++;
					$display("%0t: row_index expected %0d got %0d", $time, head.row,
						m_axis_tdata[SUM_W +: ROW_W]);
				end
				if (m_axis_tdata[SUM_W+ROW_W +: COL_W] !== head.col) begin
					mismatches++;
					$display("%0t: col_index expected %0d got %0d", $time, head.col,
						m_axis_tdata[SUM_W+ROW_W +: COL_W]);
				end
				if (m_axis_tlast !== head.last) begin
					mismatches++;
					$display("%0t: tlast expected %b got %b", $time, head.last, m_axis_tlast);
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= sink_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [IN_DATA_W-1:0] d;
		int unsigned depth_pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				wait_quiet();
				write_reg(plan[r].reg_idx, plan[r].reg_val);
			end else begin
				for (int i = 0; i < TILE_ROWS; i++)
					d[i*COORD_W +: COORD_W] = plan[r].a_val;
				for (int j = 0; j < TILE_COLS; j++)
					d[(TILE_ROWS+j)*COORD_W +: COORD_W] = plan[r].b_val;
				typed_on = plan[r].typed;
				typed_distance = plan[r].distance;
				repeat (plan[r].reps) push_step(d);
				typed_on = 1'b0;
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			wait_quiet();
			src_idle = (phase == 0) ? 11 : (phase == 1) ? 82 : 0;
			sink_idle = (phase == 0) ? 82 : (phase == 1) ? 11 : 0;
			for (int seg = 0; seg < 5; seg++) begin
				wait_quiet();
				depth_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) :
					$urandom_range(0, 6);
				write_reg(REG_DEPTH, DEPTH_W'(depth_pick));
				write_reg(REG_ACCUM_PRIOR, DEPTH_W'($urandom_range(0, 1)));
				repeat (8) begin
					for (int k = 0; k < TILE_ROWS + TILE_COLS; k++)
						d[k*COORD_W +: COORD_W] = rand_coord();
					push_step(d);
				end
			end
		end

		wait_quiet();
		if (mismatches == 0 && pending_distances.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
